@@ sv/r2fft_pkg.sv @@
package r2fft_pkg;

  localparam int FRAME_POINTS = 64;
  localparam int LOG_POINTS   = 6;
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;
  localparam int TW_FRAC      = TWIDDLE_BITS - 1;
  localparam int DATA_W       = 23;
  localparam int BIN_W        = 6;
  localparam int MAG_W        = 22;
  localparam int WORD_W       = 2 * DATA_W;
  localparam int PROD_W       = DATA_W + 1 + TWIDDLE_BITS;
  localparam int ACC_W        = PROD_W + 1;
  localparam int SQ_W         = 2 * DATA_W;
  localparam int ROOT_W       = DATA_W;
  localparam int REM_W        = ROOT_W + 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(FRAME_POINTS / 2);

  // One finished bin, handed from the transform engine to the magnitude unit.
  typedef struct packed {
    logic [BIN_W-1:0]         bin;
    logic                     last;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } bin_word_t;

  // Quarter-wave cosine table, Q1.15 scale with 1.0 held as 32768.
  function automatic logic signed [16:0] cos_tab(input logic [4:0] idx);
    logic signed [16:0] v;
    case (idx)
      5'd0:    v = 17'sd32768;
      5'd1:    v = 17'sd32610;
      5'd2:    v = 17'sd32138;
      5'd3:    v = 17'sd31357;
      5'd4:    v = 17'sd30274;
      5'd5:    v = 17'sd28899;
      5'd6:    v = 17'sd27246;
      5'd7:    v = 17'sd25330;
      5'd8:    v = 17'sd23170;
      5'd9:    v = 17'sd20788;
      5'd10:   v = 17'sd18205;
      5'd11:   v = 17'sd15447;
      5'd12:   v = 17'sd12540;
      5'd13:   v = 17'sd9512;
      5'd14:   v = 17'sd6393;
      5'd15:   v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  // Real part of exp(-j*2*pi*m/N), clamped to the signed twiddle range.
  function automatic logic signed [TWIDDLE_BITS-1:0] tw_re(input logic [4:0] m);
    logic signed [16:0] v;
    if (m <= 5'd16) begin
      v = cos_tab(m);
    end else begin
      v = -cos_tab(5'(6'd32 - {1'b0, m}));
    end
    if (v > 17'sd32767) begin
      v = 17'sd32767;
    end
    return TWIDDLE_BITS'(v);
  endfunction

  // Imaginary part of exp(-j*2*pi*m/N), which is minus the sine.
  function automatic logic signed [TWIDDLE_BITS-1:0] tw_im(input logic [4:0] m);
    logic signed [16:0] s;
    if (m <= 5'd16) begin
      s = cos_tab(5'd16 - m);
    end else begin
      s = cos_tab(m - 5'd16);
    end
    return TWIDDLE_BITS'(-s);
  endfunction

  function automatic logic [LOG_POINTS-1:0] bit_rev(input logic [LOG_POINTS-1:0] v);
    logic [LOG_POINTS-1:0] r;
    for (int i = 0; i < LOG_POINTS; i++) begin
      r[i] = v[LOG_POINTS-1-i];
    end
    return r;
  endfunction

endpackage

@@ sv/r2fft_ram.sv @@
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ sv/r2fft_engine.sv @@
module r2fft_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                 queue_full,
  input  logic                                 drain_done,
  output logic                                 busy,
  output logic                                 push,
  output r2fft_pkg::bin_word_t                 push_word
);
  import r2fft_pkg::*;

  typedef enum logic [10:0] {
    ST_LOAD  = 11'b00000000001,
    ST_RD    = 11'b00000000010,
    ST_DIF   = 11'b00000000100,
    ST_MUL   = 11'b00000001000,
    ST_MFIN  = 11'b00000010000,
    ST_RND   = 11'b00000100000,
    ST_WRA   = 11'b00001000000,
    ST_WRB   = 11'b00010000000,
    ST_ORD   = 11'b00100000000,
    ST_OPUSH = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } eng_state_t;

  eng_state_t state, state_next;

  logic [LOG_POINTS-1:0] cnt;
  logic [2:0]            stage;
  logic [4:0]            bf;
  logic [1:0]            mcnt;
  logic [BIN_W-1:0]      bin;

  logic signed [DATA_W-1:0]       sum_re, sum_im, res_re, res_im;
  logic signed [DATA_W:0]         dr, di;
  logic signed [TWIDDLE_BITS-1:0] wr, wi;
  logic signed [PROD_W-1:0]       prod;
  logic [1:0]                     psel;
  logic                           pvld;
  logic signed [ACC_W-1:0]        acc_re, acc_im;

  logic [4:0]            hmask, k, m;
  logic [LOG_POINTS-1:0] a_addr, b_addr;
  logic                  accept;

  logic                  we;
  logic [LOG_POINTS-1:0] waddr, raddr0;
  logic [WORD_W-1:0]     wdata, rdata0, rdata1;

  logic signed [DATA_W-1:0]       a_re, a_im, b_re, b_im;
  logic signed [DATA_W:0]         op_a;
  logic signed [TWIDDLE_BITS-1:0] op_b;
  logic signed [ACC_W:0]          rnd_re, rnd_im;

  assign accept = start && (state == ST_LOAD);
  assign busy   = (state != ST_LOAD);

  // Butterfly addressing: span halves with each stage.
  assign hmask  = 5'd31 >> stage;
  assign k      = bf & hmask;
  assign a_addr = {bf & ~hmask, 1'b0} | {1'b0, k};
  assign b_addr = a_addr | (6'd32 >> stage);
  assign m      = 5'(k << stage);

  assign a_re = rdata0[WORD_W-1:DATA_W];
  assign a_im = rdata0[DATA_W-1:0];
  assign b_re = rdata1[WORD_W-1:DATA_W];
  assign b_im = rdata1[DATA_W-1:0];

  // The first butterfly of each group needs no twiddle.
  function automatic logic kzero_n();
    return (k == 5'd0);
  endfunction

  // Store port selection.
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {DATA_W'(sample), {DATA_W{1'b0}}};
    if (accept) begin
      we = 1'b1;
    end else if (state == ST_WRA) begin
      we    = 1'b1;
      waddr = a_addr;
      wdata = {sum_re, sum_im};
    end else if (state == ST_WRB) begin
      we    = 1'b1;
      waddr = b_addr;
      wdata = {res_re, res_im};
    end
    raddr0 = (state == ST_ORD) ? bit_rev(bin) : a_addr;
  end

  r2fft_ram #(.WIDTH(WORD_W), .DEPTH(FRAME_POINTS)) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (b_addr),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (accept && cnt == LOG_POINTS'(FRAME_POINTS - 1)) state_next = ST_RD;
      ST_RD:    state_next = ST_DIF;
      ST_DIF:   state_next = kzero_n() ? ST_WRA : ST_MUL;
      ST_MUL:   if (mcnt == 2'd3) state_next = ST_MFIN;
      ST_MFIN:  state_next = ST_RND;
      ST_RND:   state_next = ST_WRA;
      ST_WRA:   state_next = ST_WRB;
      ST_WRB: begin
        if (bf == 5'd31 && stage == 3'(LOG_POINTS - 1)) state_next = ST_ORD;
        else state_next = ST_RD;
      end
      ST_ORD:   if (!queue_full) state_next = ST_OPUSH;
      ST_OPUSH: state_next = (bin == LAST_BIN) ? ST_DONE : ST_ORD;
      ST_DONE:  if (drain_done) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      stage <= '0;
      bf    <= '0;
      mcnt  <= '0;
      bin   <= '0;
      pvld  <= 1'b0;
    end else begin
      state <= state_next;
      pvld  <= (state == ST_MUL);
      if (accept) begin
        cnt <= cnt + 1'b1;
      end
      if (state == ST_MUL) begin
        mcnt <= mcnt + 1'b1;
      end
      if (state == ST_WRB) begin
        bf <= bf + 1'b1;
        if (bf == 5'd31) begin
          stage <= (stage == 3'(LOG_POINTS - 1)) ? 3'd0 : stage + 1'b1;
        end
      end
      if (state == ST_OPUSH) begin
        bin <= (bin == LAST_BIN) ? '0 : bin + 1'b1;
      end
    end
  end

  // Multiplier operand selection for the four partial products.
  assign op_a = mcnt[0] ? di : dr;
  assign op_b = (mcnt == 2'd0 || mcnt == 2'd3) ? wr : wi;

  // Round half up by dropping the fraction bits of the twiddle.
  assign rnd_re = (ACC_W + 1)'(acc_re) + (ACC_W + 1)'(1 << (TW_FRAC - 1));
  assign rnd_im = (ACC_W + 1)'(acc_im) + (ACC_W + 1)'(1 << (TW_FRAC - 1));

  // Butterfly datapath.
  always_ff @(posedge clk) begin
    if (state == ST_DIF) begin
      sum_re <= a_re + b_re;
      sum_im <= a_im + b_im;
      dr     <= (DATA_W + 1)'(a_re) - (DATA_W + 1)'(b_re);
      di     <= (DATA_W + 1)'(a_im) - (DATA_W + 1)'(b_im);
      res_re <= a_re - b_re;
      res_im <= a_im - b_im;
      wr     <= tw_re(m);
      wi     <= tw_im(m);
    end
    if (state == ST_MUL) begin
      prod <= op_a * op_b;
      psel <= mcnt;
    end
    if (pvld) begin
      case (psel)
        2'd0:    acc_re <= ACC_W'(prod);
        2'd1:    acc_re <= acc_re - ACC_W'(prod);
        2'd2:    acc_im <= ACC_W'(prod);
        default: acc_im <= acc_im + ACC_W'(prod);
      endcase
    end
    if (state == ST_RND) begin
      res_re <= DATA_W'(rnd_re >>> TW_FRAC);
      res_im <= DATA_W'(rnd_im >>> TW_FRAC);
    end
  end

  // Bins leave in natural order, read from bit-reversed addresses.
  assign push           = (state == ST_OPUSH);
  assign push_word.bin  = bin;
  assign push_word.last = (bin == LAST_BIN);
  assign push_word.re   = a_re;
  assign push_word.im   = a_im;

endmodule

@@ sv/r2fft_queue.sv @@
module r2fft_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  r2fft_pkg::bin_word_t push_word,
  input  logic                 pop,
  output r2fft_pkg::bin_word_t pop_word,
  output logic                 full,
  output logic                 empty
);
  import r2fft_pkg::*;

  bin_word_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QPTR_W:0]     count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_word = slots[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_word;
    end
  end

endmodule

@@ sv/r2fft_mag.sv @@
module r2fft_mag (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                queue_empty,
  input  r2fft_pkg::bin_word_t                pop_word,
  output logic                                pop,
  output logic                                idle,
  output logic                                valid,
  output logic [r2fft_pkg::BIN_W-1:0]         bin_index,
  output logic signed [r2fft_pkg::DATA_W-1:0] real_part,
  output logic signed [r2fft_pkg::DATA_W-1:0] imag_part,
  output logic [r2fft_pkg::MAG_W-1:0]         magnitude,
  output logic                                last_bin
);
  import r2fft_pkg::*;

  typedef enum logic [5:0] {
    MS_IDLE = 6'b000001,
    MS_SQR  = 6'b000010,
    MS_SQI  = 6'b000100,
    MS_SUM  = 6'b001000,
    MS_ROOT = 6'b010000,
    MS_EMIT = 6'b100000
  } mag_state_t;

  mag_state_t state;

  logic signed [SQ_W-1:0] sq;
  logic [SQ_W-1:0]        rad;
  logic [REM_W-1:0]       rem, rem_sh, trial;
  logic [ROOT_W-1:0]      root;
  logic [4:0]             iter;

  assign pop   = (state == MS_IDLE) && !queue_empty;
  assign idle  = (state == MS_IDLE);
  assign valid = (state == MS_EMIT);

  // One root bit per cycle: bring down two radicand bits, try to subtract.
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1:SQ_W-2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      iter  <= '0;
    end else begin
      case (state)
        MS_IDLE: if (!queue_empty) state <= MS_SQR;
        MS_SQR:  state <= MS_SQI;
        MS_SQI:  state <= MS_SUM;
        MS_SUM: begin
          state <= MS_ROOT;
          iter  <= '0;
        end
        MS_ROOT: begin
          iter <= iter + 1'b1;
          if (iter == 5'(ROOT_W - 1)) state <= MS_EMIT;
        end
        MS_EMIT: state <= MS_IDLE;
        default: state <= MS_IDLE;
      endcase
    end
  end

  // Squares through one multiplier, then the square root.
  always_ff @(posedge clk) begin
    case (state)
      MS_IDLE: begin
        bin_index <= pop_word.bin;
        last_bin  <= pop_word.last;
        real_part <= pop_word.re;
        imag_part <= pop_word.im;
      end
      MS_SQR: sq <= real_part * real_part;
      MS_SQI: begin
        rad <= SQ_W'(sq);
        sq  <= imag_part * imag_part;
      end
      MS_SUM: begin
        rad  <= rad + SQ_W'(sq);
        rem  <= '0;
        root <= '0;
      end
      MS_ROOT: begin
        rad <= {rad[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign magnitude = root[MAG_W-1:0];

endmodule

@@ sv/radix2_dif_fft_magnitude_unit.sv @@
// Radix-2 decimation-in-frequency FFT of 64 real samples with bin magnitudes.
// Input: drive a sample word and raise start; the word is taken at a clock edge
// where start is high and busy is low. Samples 0..63 of a frame go in order.
// The 64th sample raises busy, and busy stays high until the last bin is out.
// Output: bins 0..32 leave in natural order, each shown for exactly one cycle
// with valid high; last_bin marks bin 32. The receiver cannot stall.
// Sequencing: each butterfly with a twiddle steps through read, sum and
// difference, four products through one shared multiplier, final accumulate,
// round and two writes; one without a twiddle skips the products, accumulate
// and round. A frame has 129 twiddled and 63 plain butterflies, run one at
// a time through the single multiplier and the one write port of the store.
// Each bin then goes through the magnitude unit (two squares and a 23-step
// bit-serial square root), which takes the next bin from the queue only once
// it is through with the last one.
// Loading accepts one sample per cycle while busy is low.
// Reset: synchronous, clears the sample count, the bin queue and all
// sequencers; the frame store holds no reset value and is fully rewritten by
// every frame before it is read.
module radix2_dif_fft_magnitude_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                    busy,
  output logic                                    valid,
  output logic [r2fft_pkg::BIN_W-1:0]             bin_index,
  output logic signed [r2fft_pkg::DATA_W-1:0]     real_part,
  output logic signed [r2fft_pkg::DATA_W-1:0]     imag_part,
  output logic [r2fft_pkg::MAG_W-1:0]             magnitude,
  output logic                                    last_bin
);
  import r2fft_pkg::*;

  bin_word_t push_word, pop_word;
  logic      push, pop, queue_full, queue_empty, mag_idle;

  r2fft_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .sample     (sample),
    .queue_full (queue_full),
    .drain_done (queue_empty && mag_idle),
    .busy       (busy),
    .push       (push),
    .push_word  (push_word)
  );

  r2fft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  r2fft_mag u_mag (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop_word    (pop_word),
    .pop         (pop),
    .idle        (mag_idle),
    .valid       (valid),
    .bin_index   (bin_index),
    .real_part   (real_part),
    .imag_part   (imag_part),
    .magnitude   (magnitude),
    .last_bin    (last_bin)
  );

endmodule

@@ sv/r2fft_checker.sv @@
module r2fft_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic valid,
  input logic last_bin
);

  // Results only come out while a frame is being worked on.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result word outside a busy period");

  // Two result words never come out back to back.
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result words in consecutive cycles");

  // After the last bin the block stays busy until the frame is closed.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    valid && last_bin |=> busy) else $error("busy dropped with the last bin");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !valid) else $error("result word right after reset");

endmodule

bind radix2_dif_fft_magnitude_unit r2fft_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .valid    (valid),
  .last_bin (last_bin)
);

@@ verif/fft_bin_checker.sv @@
`timescale 1ns / 100ps

module fft_bin_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                     busy,
  input  logic                                     valid,
  input  logic [r2fft_pkg::BIN_W-1:0]              bin_index,
  input  logic signed [r2fft_pkg::DATA_W-1:0]      real_part,
  input  logic signed [r2fft_pkg::DATA_W-1:0]      imag_part,
  input  logic [r2fft_pkg::MAG_W-1:0]              magnitude,
  input  logic                                     last_bin,
  output int                                       errors,
  output int                                       pending
);
  import r2fft_pkg::*;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef struct {
    logic [BIN_W-1:0]  bin;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [MAG_W-1:0]  mag;
    logic              last;
  } bin_rec_t;

  bin_rec_t   spectrum_q[$];
  longint     frame_re[FRAME_POINTS];
  longint     frame_im[FRAME_POINTS];
  int         load_idx;

  // Divide by 2^sh with rounding half toward plus infinity.
  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Sine and cosine of an angle in Q2.30 by a truncated Taylor series.
  function automatic void series_sincos(logic [63:0] x, output longint s, output longint c);
    logic [63:0] x2, ts, tc;
    longint n;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s = longint'(x);
    c = longint'(tc);
    for (n = 1; n <= 10; n++) begin
      ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n[0]) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
  endfunction

  function automatic longint q15_clamp(longint v30);
    longint v;
    v = round_half_up(v30, 31 - TWIDDLE_BITS);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Twiddle exp(-j*2*pi*m/N) for 0 < m < N/2.
  function automatic void rotation(int m, output longint wr, output longint wi);
    int q, r;
    logic [63:0] x;
    longint s, c;
    q = m / (FRAME_POINTS / 4);
    r = m % (FRAME_POINTS / 4);
    x = (((PI_Q60 >> 20) * (64'd2 * r)) / FRAME_POINTS) >> 10;
    series_sincos(x, s, c);
    if (q == 0) begin
      wr = q15_clamp(c);
      wi = q15_clamp(-s);
    end else begin
      wr = q15_clamp(-s);
      wi = q15_clamp(-c);
    end
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Run the in-place transform on the loaded frame and queue bins 0..N/2.
  task automatic transform_frame();
    int p, h, j, k, a, b, rev, i;
    longint dr, di, wr, wi, re, im, ar, ai;
    bin_rec_t rec;
    for (p = FRAME_POINTS; p >= 2; p /= 2) begin
      h = p / 2;
      for (j = 0; j < FRAME_POINTS / p; j++) begin
        for (k = 0; k < h; k++) begin
          a = j * p + k;
          b = a + h;
          dr = frame_re[a] - frame_re[b];
          di = frame_im[a] - frame_im[b];
          frame_re[a] += frame_re[b];
          frame_im[a] += frame_im[b];
          if (k != 0) begin
            rotation(k * (FRAME_POINTS / p), wr, wi);
            frame_re[b] = round_half_up(dr * wr - di * wi, TW_FRAC);
            frame_im[b] = round_half_up(dr * wi + di * wr, TW_FRAC);
          end else begin
            frame_re[b] = dr;
            frame_im[b] = di;
          end
        end
      end
    end
    for (int n = 0; n <= FRAME_POINTS / 2; n++) begin
      rev = 0;
      for (i = 0; i < LOG_POINTS; i++) rev = (rev << 1) | ((n >> i) & 1);
      re = frame_re[rev];
      im = frame_im[rev];
      ar = re < 0 ? -re : re;
      ai = im < 0 ? -im : im;
      rec.bin  = BIN_W'(n);
      rec.re   = DATA_W'(re);
      rec.im   = DATA_W'(im);
      rec.mag  = MAG_W'(floor_sqrt(64'(ar * ar + ai * ai)));
      rec.last = (n == FRAME_POINTS / 2);
      spectrum_q.push_back(rec);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    load_idx = 0;
  end

  // Load accepted sample words and compare each emitted bin.
  always @(posedge clk) begin
    bin_rec_t want;
    if (!rst) begin
      if (valid) begin
        if (spectrum_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected bin word: bin %0d re %0d im %0d mag %0d", bin_index,
                     real_part, imag_part, magnitude);
        end else begin
          want = spectrum_q.pop_front();
          if (bin_index !== want.bin || real_part !== want.re || imag_part !== want.im ||
              magnitude !== want.mag || last_bin !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("bin mismatch: exp bin %0d re %0d im %0d mag %0d last %0d, got bin %0d re %0d im %0d mag %0d last %0d",
                       want.bin, $signed(want.re), $signed(want.im), want.mag, want.last,
                       bin_index, real_part, imag_part, magnitude, last_bin);
          end
        end
      end
      if (start && !busy) begin
        frame_re[load_idx] = longint'(sample);
        frame_im[load_idx] = 0;
        load_idx++;
        if (load_idx == FRAME_POINTS) begin
          load_idx = 0;
          transform_frame();
        end
      end
      pending = spectrum_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import r2fft_pkg::*;

  localparam int WORD_COUNT = 470;
  localparam int STALL_LIMIT = 20000;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          busy;
  logic                          valid;
  logic [BIN_W-1:0]              bin_index;
  logic signed [DATA_W-1:0]      real_part;
  logic signed [DATA_W-1:0]      imag_part;
  logic [MAG_W-1:0]              magnitude;
  logic                          last_bin;
  int                            errors;
  int                            pending;
  int                            quiet_cycles;

  radix2_dif_fft_magnitude_unit u_top (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .busy(busy), .valid(valid),
    .bin_index(bin_index), .real_part(real_part), .imag_part(imag_part),
    .magnitude(magnitude), .last_bin(last_bin)
  );

  fft_bin_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .busy(busy), .valid(valid),
    .bin_index(bin_index), .real_part(real_part), .imag_part(imag_part),
    .magnitude(magnitude), .last_bin(last_bin), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one sample word, holding it until it is taken.
  task automatic send_word(logic signed [SAMPLE_BITS-1:0] v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start  <= 1'b1;
    sample <= v;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int style);
    case (style)
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_BITS-1:0] edge_vals[10];
    int idle_pct, style, n;
    quiet_cycles = 0;
    rst    = 1'b1;
    start  = 1'b0;
    sample = '0;
    edge_vals = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
                  -16'sh5556, 16'sh4000, -16'sh4000, 16'sh00FF};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: full-scale frames of each sign, then a frame of edge values and alternating full-scale words.
    for (n = 0; n < FRAME_POINTS; n++) send_word(16'sh7FFF, 0);
    for (n = 0; n < FRAME_POINTS; n++) send_word(-16'sh8000, 0);
    for (n = 0; n < 20; n++) send_word(edge_vals[n % 10], 0);
    for (n = 0; n < FRAME_POINTS - 20; n++) send_word((n % 2) ? 16'sh7FFF : -16'sh8000, 0);

    // Random frames across idling phases; each frame has one style.
    n = 3 * FRAME_POINTS;
    while (n < WORD_COUNT) begin
      case ((n / FRAME_POINTS) % 3)
        0: idle_pct = 0;
        1: idle_pct = 71;
        default: idle_pct = 15;
      endcase
      style = $urandom_range(5);
      for (int i = 0; i < FRAME_POINTS && n < WORD_COUNT; i++) begin
        send_word(pick_sample(style), idle_pct);
        n++;
      end
      // Hold off once until the spectrum has drained.
      if (n == 4 * FRAME_POINTS) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
